### src/jpdmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint PD mode controller package
// Shared types, register map, reset values and the clamp helper.
// ----------------------------------------------------------------------------
package jpdmc_pkg;

   localparam int NumJointsDef = 12;
   localparam int CsrAddrW     = 4;

   typedef enum logic [1:0] {
      MODE_POS  = 2'd0,
      MODE_VEL  = 2'd1,
      MODE_TRQ  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [CsrAddrW-1:0] {
      REG_PROP_GAIN    = 4'd0,
      REG_DERIV_GAIN   = 4'd1,
      REG_POS_LOWER    = 4'd2,
      REG_POS_UPPER    = 4'd3,
      REG_VEL_LOWER    = 4'd4,
      REG_VEL_UPPER    = 4'd5,
      REG_TORQUE_LOWER = 4'd6,
      REG_TORQUE_UPPER = 4'd7
   } csr_addr_type;

   typedef struct packed {
      logic        [15:0] prop_gain;
      logic        [15:0] deriv_gain;
      logic signed [15:0] pos_lower;
      logic signed [15:0] pos_upper;
      logic signed [15:0] vel_lower;
      logic signed [15:0] vel_upper;
      logic signed [15:0] torque_lower;
      logic signed [15:0] torque_upper;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      prop_gain:    16'd17920,
      deriv_gain:   16'd794,
      pos_lower:    16'sh8000,
      pos_upper:    16'sh7FFF,
      vel_lower:    16'sh8000,
      vel_upper:    16'sh7FFF,
      torque_lower: 16'sh8000,
      torque_upper: 16'sh7FFF
   };

   // Per-joint state word kept in the state memory.
   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] held;
   } jstate_type;

   localparam jstate_type StateReset = '{mode: MODE_NONE, held: 16'sd0};

   // Item handed from the state stage to the torque pipeline.
   typedef struct packed {
      logic        [3:0]  joint;
      logic               err;
      mode_type           mode;
      logic signed [15:0] upos;
      logic signed [15:0] uvel;
      logic signed [15:0] ttrq;
      logic signed [16:0] pos_err;
      logic signed [16:0] vel_err;
   } pd_item_type;

   // Crossed limits: the upper limit is checked first; else the lower wins.
   function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                  input logic signed [15:0] lo,
                                                  input logic signed [15:0] hi);
      logic signed [15:0] r;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### src/jpdmc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint PD mode controller channel interfaces
// Command, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface jpdmc_req_if;
   logic               valid;
   logic               ready;
   logic        [3:0]  joint_id;
   logic        [1:0]  ctrl_mode;
   logic signed [15:0] target_pos;
   logic signed [15:0] target_vel;
   logic signed [15:0] target_torque;
   logic signed [15:0] meas_pos;
   logic signed [15:0] meas_vel;

   modport source (output valid, joint_id, ctrl_mode, target_pos, target_vel,
                   target_torque, meas_pos, meas_vel, input ready);
   modport sink (input valid, joint_id, ctrl_mode, target_pos, target_vel,
                 target_torque, meas_pos, meas_vel, output ready);
endinterface

interface jpdmc_rsp_if;
   logic               valid;
   logic               ready;
   logic        [3:0]  joint_out;
   logic signed [15:0] drive_torque;
   logic signed [15:0] used_pos;
   logic signed [15:0] used_vel;
   logic               mode_error;

   modport source (output valid, joint_out, drive_torque, used_pos, used_vel,
                   mode_error, input ready);
   modport sink (input valid, joint_out, drive_torque, used_pos, used_vel,
                 mode_error, output ready);
endinterface

interface jpdmc_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  addr;
   logic [15:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

### src/jpdmc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint PD mode controller register file
// Holds gains and limits; writes are always accepted, as ready is tied high.
// ----------------------------------------------------------------------------
module jpdmc_csr (
   input  logic              clock,
   input  logic              reset,
   jpdmc_csr_if.sink         csr_bus,
   output jpdmc_pkg::cfg_type cfg
);
   import jpdmc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            REG_PROP_GAIN:    cfg_in.prop_gain    = csr_bus.data;
            REG_DERIV_GAIN:   cfg_in.deriv_gain   = csr_bus.data;
            REG_POS_LOWER:    cfg_in.pos_lower    = csr_bus.data;
            REG_POS_UPPER:    cfg_in.pos_upper    = csr_bus.data;
            REG_VEL_LOWER:    cfg_in.vel_lower    = csr_bus.data;
            REG_VEL_UPPER:    cfg_in.vel_upper    = csr_bus.data;
            REG_TORQUE_LOWER: cfg_in.torque_lower = csr_bus.data;
            REG_TORQUE_UPPER: cfg_in.torque_upper = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/jpdmc_state_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint PD mode controller state memory
// One entry per joint, registered read, write-first bypass, per-entry valid.
// ----------------------------------------------------------------------------
module jpdmc_state_ram #(
   parameter  int NUM_JOINTS = jpdmc_pkg::NumJointsDef,
   localparam int AddrW      = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [AddrW-1:0]      rd_addr,
   output jpdmc_pkg::jstate_type rd_data,
   input  logic                  wr_en,
   input  logic [AddrW-1:0]      wr_addr,
   input  jpdmc_pkg::jstate_type wr_data
);
   import jpdmc_pkg::*;

   jstate_type            mem [NUM_JOINTS];
   logic [NUM_JOINTS-1:0] valid_ff;
   jstate_type            rd_data_ff;

   assign rd_data = rd_data_ff;

   // An entry never written since reset reads as the reset state.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (!valid_ff[rd_addr]) begin
            rd_data_ff <= StateReset;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

endmodule

### src/jpdmc_torque_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint PD mode controller torque pipeline
// Error register, gain multiplies, then rounding, saturation and clamping.
// ----------------------------------------------------------------------------
module jpdmc_torque_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  jpdmc_pkg::cfg_type     cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  jpdmc_pkg::pd_item_type in_item,
   jpdmc_rsp_if.source            rsp_bus
);
   import jpdmc_pkg::*;

   logic               a_valid_ff;
   pd_item_type        a_item_ff;
   logic               b_valid_ff;
   pd_item_type        b_item_ff;
   logic signed [33:0] p_ff;
   logic signed [33:0] d_ff;
   logic signed [33:0] p_in;
   logic signed [33:0] d_in;
   logic               o_valid_ff;
   logic        [3:0]  o_joint_ff;
   logic signed [15:0] o_trq_ff;
   logic signed [15:0] o_upos_ff;
   logic signed [15:0] o_uvel_ff;
   logic               o_err_ff;
   logic signed [15:0] trq_in;

   logic               b_ready;
   logic               o_ready;
   logic signed [35:0] sum;
   logic signed [23:0] rnd;
   logic signed [15:0] sat;
   logic signed [15:0] pre;

   assign o_ready  = !o_valid_ff || rsp_bus.ready;
   assign b_ready  = !b_valid_ff || o_ready;
   assign in_ready = !a_valid_ff || b_ready;

   assign p_in = $signed({1'b0, cfg.prop_gain}) * a_item_ff.pos_err;
   assign d_in = $signed({1'b0, cfg.deriv_gain}) * a_item_ff.vel_err;

   // The D term is in Q.19 and is doubled to line up with the P term in Q.20.
   // Taking the upper bits of the biased sum is the floor of the shift.
   always_comb begin
      sum = $signed({{2{p_ff[33]}}, p_ff}) + $signed({d_ff[33], d_ff, 1'b0})
            + 36'sd2048;
      rnd = sum[35:12];
      if (rnd > 24'sd32767) begin
         sat = 16'sh7FFF;
      end else if (rnd < -24'sd32768) begin
         sat = 16'sh8000;
      end else begin
         sat = rnd[15:0];
      end
      pre = (b_item_ff.mode == MODE_TRQ) ? b_item_ff.ttrq : sat;
      if (b_item_ff.err) begin
         trq_in = 16'sd0;
      end else begin
         trq_in = clamp16(pre, cfg.torque_lower, cfg.torque_upper);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (o_ready) begin
            o_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_item_ff <= in_item;
      end
      if (b_ready && a_valid_ff) begin
         b_item_ff <= a_item_ff;
         p_ff      <= p_in;
         d_ff      <= d_in;
      end
      if (o_ready && b_valid_ff) begin
         o_joint_ff <= b_item_ff.joint;
         o_trq_ff   <= trq_in;
         o_upos_ff  <= b_item_ff.upos;
         o_uvel_ff  <= b_item_ff.uvel;
         o_err_ff   <= b_item_ff.err;
      end
   end

   assign rsp_bus.valid        = o_valid_ff;
   assign rsp_bus.joint_out    = o_joint_ff;
   assign rsp_bus.drive_torque = o_trq_ff;
   assign rsp_bus.used_pos     = o_upos_ff;
   assign rsp_bus.used_vel     = o_uvel_ff;
   assign rsp_bus.mode_error   = o_err_ff;

endmodule

### src/joint_pd_mode_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint PD mode controller
// Per-joint PD torque with position, velocity and torque modes.
// ----------------------------------------------------------------------------
//   Channel   Role    Handshake     Carries
//   req_bus   in      valid/ready   one joint command
//   rsp_bus   out     valid/ready   torque, used targets, mode error
//   csr_bus   in      valid/ready   register index and 16-bit value
//
// One item is accepted per cycle unless the result side stalls. The rate is
// set by the state memory read-modify-write, whose write-first bypass lets
// consecutive items hit the same joint.
// Reset clears the per-joint valid bits at once; no clearing pass is needed.
// Each stage holds only while the stage after it is full and stalled.
// ----------------------------------------------------------------------------
module joint_pd_mode_controller_core #(
   parameter  int NUM_JOINTS = jpdmc_pkg::NumJointsDef,
   localparam int AddrW      = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
   input  logic       clock,
   input  logic       reset,
   jpdmc_req_if.sink  req_bus,
   jpdmc_rsp_if.source rsp_bus,
   jpdmc_csr_if.sink  csr_bus
);
   import jpdmc_pkg::*;

   cfg_type            cfg;
   jstate_type         st;
   jstate_type         wr_data;
   pd_item_type        item;
   logic               pipe_ready;

   logic               s1_valid_ff;
   logic        [3:0]  s1_joint_ff;
   logic               s1_range_ff;
   mode_type           s1_mode_ff;
   logic signed [15:0] s1_tpos_ff;
   logic signed [15:0] s1_tvel_ff;
   logic signed [15:0] s1_ttrq_ff;
   logic signed [15:0] s1_mpos_ff;
   logic signed [15:0] s1_mvel_ff;

   logic               accept;
   logic               s1_go;
   logic               in_range;
   logic [AddrW-1:0]   rd_addr;
   logic               err;
   logic signed [15:0] upos;
   logic signed [15:0] uvel;
   logic signed [15:0] held_new;
   logic signed [15:0] pos_ref;
   logic signed [15:0] vel_ref;
   logic               wr_en;

   assign in_range      = {28'd0, req_bus.joint_id} < NUM_JOINTS;
   assign rd_addr       = in_range ? AddrW'(req_bus.joint_id) : '0;
   assign s1_go         = s1_valid_ff && pipe_ready;
   assign req_bus.ready = !s1_valid_ff || pipe_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   jpdmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   jpdmc_state_ram #(.NUM_JOINTS(NUM_JOINTS)) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (st),
      .wr_en   (wr_en),
      .wr_addr (AddrW'(s1_joint_ff)),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_joint_ff <= req_bus.joint_id;
         s1_range_ff <= in_range;
         s1_mode_ff  <= mode_type'(req_bus.ctrl_mode);
         s1_tpos_ff  <= req_bus.target_pos;
         s1_tvel_ff  <= req_bus.target_vel;
         s1_ttrq_ff  <= req_bus.target_torque;
         s1_mpos_ff  <= req_bus.meas_pos;
         s1_mvel_ff  <= req_bus.meas_vel;
      end
   end

   // Entering velocity mode latches a hold position: the measured position
   // if the joint has seen no valid command yet, else the raw target position.
   // A rejected item passes its targets through unclamped.
   always_comb begin
      err  = (s1_mode_ff == MODE_NONE) || !s1_range_ff;
      upos = ((s1_mode_ff == MODE_POS) && !err) ?
             clamp16(s1_tpos_ff, cfg.pos_lower, cfg.pos_upper) : s1_tpos_ff;
      uvel = ((s1_mode_ff == MODE_VEL) && !err) ?
             clamp16(s1_tvel_ff, cfg.vel_lower, cfg.vel_upper) : s1_tvel_ff;
      if (st.mode == MODE_NONE) begin
         held_new = s1_mpos_ff;
      end else if (st.mode != MODE_VEL) begin
         held_new = s1_tpos_ff;
      end else begin
         held_new = st.held;
      end
      pos_ref = (s1_mode_ff == MODE_VEL) ? held_new : upos;
      vel_ref = (s1_mode_ff == MODE_VEL) ? uvel : s1_tvel_ff;

      wr_en        = s1_go && !err;
      wr_data.mode = s1_mode_ff;
      wr_data.held = (s1_mode_ff == MODE_VEL) ? held_new : st.held;

      item.joint   = s1_joint_ff;
      item.err     = err;
      item.mode    = s1_mode_ff;
      item.upos    = upos;
      item.uvel    = uvel;
      item.ttrq    = s1_ttrq_ff;
      item.pos_err = {pos_ref[15], pos_ref} - {s1_mpos_ff[15], s1_mpos_ff};
      item.vel_err = {vel_ref[15], vel_ref} - {s1_mvel_ff[15], s1_mvel_ff};
   end

   jpdmc_torque_pipe u_pipe (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (s1_valid_ff),
      .in_ready (pipe_ready),
      .in_item  (item),
      .rsp_bus  (rsp_bus)
   );

endmodule

### bench/jpdmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint PD mode controller result checker
// Watches the command, result and register channels, keeps its own copy of
// the gains, limits and per-joint mode state, predicts every result in order
// and compares each returned result field by field.
// ----------------------------------------------------------------------------
module jpdmc_checker #(
   parameter int NUM_JOINTS = 12
) (
   input  logic  clock,
   input  logic  reset,
   jpdmc_req_if  req_mon,
   jpdmc_rsp_if  rsp_mon,
   jpdmc_csr_if  csr_mon,
   output int    fail_count,
   output int    pending
);
   import jpdmc_pkg::*;

   typedef struct packed {
      logic        [3:0]  joint;
      logic signed [15:0] torque;
      logic signed [15:0] upos;
      logic signed [15:0] uvel;
      logic               err;
   } joint_result_type;

   cfg_type            gains;
   mode_type           prev_mode [NUM_JOINTS];
   logic signed [15:0] hold_pos  [NUM_JOINTS];
   joint_result_type   torque_queue [$];
   int                 misses;

   initial begin
      misses     = 0;
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (misses < 50) begin
         $display("%0t ns  mismatch: %s  got %0d  expected %0d", $time, what, got, want);
      end
      misses++;
   endtask

   function automatic logic signed [15:0] limit_to(input logic signed [15:0] v,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
      logic signed [15:0] r;
      r = v;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end
      return r;
   endfunction

   // Errors are exact 17-bit values; the derivative product is one binary
   // place short, so it is doubled before the Q8.8 round-half-up.
   function automatic logic signed [15:0] pd_law(input logic signed [15:0] aim_pos,
                                                 input logic signed [15:0] pos,
                                                 input logic signed [15:0] aim_vel,
                                                 input logic signed [15:0] vel);
      logic signed [16:0] perr;
      logic signed [16:0] verr;
      longint             acc;
      perr = {aim_pos[15], aim_pos} - {pos[15], pos};
      verr = {aim_vel[15], aim_vel} - {vel[15], vel};
      acc  = longint'(gains.prop_gain) * longint'(perr)
           + 2 * longint'(gains.deriv_gain) * longint'(verr) + 2048;
      acc  = acc >>> 12;
      if (acc > 32767) begin
         acc = 32767;
      end else if (acc < -32768) begin
         acc = -32768;
      end
      return 16'(acc);
   endfunction

   function automatic joint_result_type predict_torque(input logic [3:0] j,
                                                       input logic [1:0] m,
                                                       input logic signed [15:0] tp,
                                                       input logic signed [15:0] tv,
                                                       input logic signed [15:0] tt,
                                                       input logic signed [15:0] mp,
                                                       input logic signed [15:0] mv);
      joint_result_type   r;
      logic signed [15:0] t;
      mode_type           md;
      md       = mode_type'(m);
      r.joint  = j;
      r.upos   = tp;
      r.uvel   = tv;
      r.torque = '0;
      r.err    = 1'b0;
      t        = '0;
      if (md == MODE_NONE || j >= NUM_JOINTS) begin
         r.err = 1'b1;
      end else begin
         case (md)
            MODE_POS: begin
               r.upos = limit_to(tp, gains.pos_lower, gains.pos_upper);
               t = pd_law(r.upos, mp, tv, mv);
            end
            MODE_VEL: begin
               r.uvel = limit_to(tv, gains.vel_lower, gains.vel_upper);
               // A joint with no history holds where it is measured; coming
               // from another mode it holds the raw commanded position.
               if (prev_mode[j] == MODE_NONE) begin
                  hold_pos[j] = mp;
               end else if (prev_mode[j] != MODE_VEL) begin
                  hold_pos[j] = tp;
               end
               t = pd_law(hold_pos[j], mp, r.uvel, mv);
            end
            default: begin
               t = tt;
            end
         endcase
         r.torque     = limit_to(t, gains.torque_lower, gains.torque_upper);
         prev_mode[j] = md;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      joint_result_type want;
      if (reset) begin
         gains = CfgReset;
         for (int i = 0; i < NUM_JOINTS; i++) begin
            prev_mode[i] = MODE_NONE;
            hold_pos[i]  = '0;
         end
         torque_queue.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_addr_type'(csr_mon.addr))
               REG_PROP_GAIN:    gains.prop_gain    = csr_mon.data;
               REG_DERIV_GAIN:   gains.deriv_gain   = csr_mon.data;
               REG_POS_LOWER:    gains.pos_lower    = csr_mon.data;
               REG_POS_UPPER:    gains.pos_upper    = csr_mon.data;
               REG_VEL_LOWER:    gains.vel_lower    = csr_mon.data;
               REG_VEL_UPPER:    gains.vel_upper    = csr_mon.data;
               REG_TORQUE_LOWER: gains.torque_lower = csr_mon.data;
               REG_TORQUE_UPPER: gains.torque_upper = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            torque_queue.push_back(predict_torque(req_mon.joint_id, req_mon.ctrl_mode,
                                                  req_mon.target_pos, req_mon.target_vel,
                                                  req_mon.target_torque, req_mon.meas_pos,
                                                  req_mon.meas_vel));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (torque_queue.size() == 0) begin
               report_mismatch("result with nothing outstanding, joint", rsp_mon.joint_out, -1);
            end else begin
               want = torque_queue.pop_front();
               if (rsp_mon.joint_out !== want.joint) begin
                  report_mismatch("joint_out", rsp_mon.joint_out, want.joint);
               end
               if (rsp_mon.drive_torque !== want.torque) begin
                  report_mismatch("drive_torque", rsp_mon.drive_torque, want.torque);
               end
               if (rsp_mon.used_pos !== want.upos) begin
                  report_mismatch("used_pos", rsp_mon.used_pos, want.upos);
               end
               if (rsp_mon.used_vel !== want.uvel) begin
                  report_mismatch("used_vel", rsp_mon.used_vel, want.uvel);
               end
               if (rsp_mon.mode_error !== want.err) begin
                  report_mismatch("mode_error", rsp_mon.mode_error, want.err);
               end
            end
         end
      end
      fail_count <= misses;
      pending    <= torque_queue.size();
   end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint PD mode controller testbench
// Drives directed and random joint commands through a series of gain and
// limit settings, with random gaps on the command side and random stalls on
// the result side; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import jpdmc_pkg::*;

   localparam int         NumJoints   = NumJointsDef;
   localparam int         NumSettings = 8;
   localparam int         PhaseItems  = 240;
   localparam logic [3:0] UnmappedReg = 4'hF;

   logic clock;
   logic reset;
   logic calm;
   logic quiet;
   int   sent;
   int   fails;
   int   pending;

   logic [3:0] cur_joint;
   mode_type   cur_mode;
   cfg_type    settings [NumSettings];

   jpdmc_req_if req_bus ();
   jpdmc_rsp_if rsp_bus ();
   jpdmc_csr_if csr_bus ();

   joint_pd_mode_controller_core #(
      .NUM_JOINTS(NumJoints)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   jpdmc_checker #(
      .NUM_JOINTS(NumJoints)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_bus),
      .rsp_mon   (rsp_bus),
      .csr_mon   (csr_bus),
      .fail_count(fails),
      .pending   (pending)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   // Result side: random stall bursts, none while quiet or once calm.
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 4) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Valid is left high after a handshake so that back-to-back items never
   // see it lowered and raised in one step.
   task automatic send_cmd(input logic [3:0] j, input mode_type m,
                           input logic signed [15:0] tp, input logic signed [15:0] tv,
                           input logic signed [15:0] tt, input logic signed [15:0] mp,
                           input logic signed [15:0] mv);
      if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.joint_id      <= j;
      req_bus.ctrl_mode     <= m;
      req_bus.target_pos    <= tp;
      req_bus.target_vel    <= tv;
      req_bus.target_torque <= tt;
      req_bus.meas_pos      <= mp;
      req_bus.meas_vel      <= mv;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
      if ($urandom_range(0, 39) == 0) begin
         quiet = !quiet;
      end
   endtask

   function automatic logic signed [15:0] pick_value();
      logic signed [15:0] v;
      case ($urandom_range(0, 7))
         0:       v = 16'sh7FFF;
         1:       v = 16'sh8000;
         2, 3:    v = 16'(int'($urandom_range(0, 1023)) - 512);
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   // Commands come mostly in runs on one joint and one mode, so velocity
   // mode is entered from every other mode and then held for a while.
   task automatic random_cmd();
      logic signed [15:0] tp;
      logic signed [15:0] tv;
      logic signed [15:0] mp;
      logic signed [15:0] mv;
      if ($urandom_range(0, 9) < 4) begin
         cur_joint = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 11));
      end
      if ($urandom_range(0, 9) < 5) begin
         cur_mode = ($urandom_range(0, 9) == 0) ? MODE_NONE
                                                : mode_type'($urandom_range(0, 2));
      end
      tp = pick_value();
      tv = pick_value();
      mp = ($urandom_range(0, 1) == 0) ? 16'(tp + int'($urandom_range(0, 255)) - 128)
                                       : pick_value();
      mv = ($urandom_range(0, 1) == 0) ? 16'(tv + int'($urandom_range(0, 255)) - 128)
                                       : pick_value();
      send_cmd(cur_joint, cur_mode, tp, tv, pick_value(), mp, mv);
   endtask

   task automatic write_reg(input logic [3:0] a, input logic [15:0] d);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= a;
      csr_bus.data  <= d;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic load_settings(input cfg_type s, input logic poke_unmapped);
      if (poke_unmapped) begin
         write_reg(UnmappedReg, 16'($urandom));
      end
      write_reg(REG_PROP_GAIN, s.prop_gain);
      write_reg(REG_DERIV_GAIN, s.deriv_gain);
      write_reg(REG_POS_LOWER, s.pos_lower);
      write_reg(REG_POS_UPPER, s.pos_upper);
      write_reg(REG_VEL_LOWER, s.vel_lower);
      write_reg(REG_VEL_UPPER, s.vel_upper);
      write_reg(REG_TORQUE_LOWER, s.torque_lower);
      write_reg(REG_TORQUE_UPPER, s.torque_upper);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic directed_cmds();
      send_cmd(0, MODE_VEL, 1000, 0, 0, 4096, 0);
      send_cmd(0, MODE_VEL, -5000, 300, 0, 0, -200);
      send_cmd(1, MODE_POS, 32767, 32767, 0, -32768, -32768);
      send_cmd(1, MODE_POS, -32768, -32768, 0, 32767, 32767);
      send_cmd(1, MODE_VEL, 12345, 100, 0, 12000, 50);
      send_cmd(2, MODE_TRQ, 0, 0, 32767, 0, 0);
      send_cmd(2, MODE_TRQ, 0, 0, -32768, 0, 0);
      send_cmd(2, MODE_VEL, -20000, -32768, 0, 32767, 32767);
      send_cmd(3, MODE_NONE, 32767, -32768, 32767, -1, 1);
      send_cmd(3, MODE_VEL, 500, 20, 0, -700, 0);
      send_cmd(12, MODE_POS, 100, 100, 100, 0, 0);
      send_cmd(15, MODE_TRQ, -1, -1, -1, -1, -1);
      send_cmd(11, MODE_POS, 0, 0, 0, 0, 0);
      send_cmd(5, MODE_POS, 1, 0, 0, 0, 0);
      send_cmd(5, MODE_POS, 0, 0, 0, 1, 0);
      send_cmd(5, MODE_POS, -1, -1, -1, -1, -1);
      send_cmd(11, MODE_VEL, 2048, 32767, 0, -2048, -32768);
      send_cmd(11, MODE_NONE, 0, 0, 0, 0, 0);
      send_cmd(11, MODE_VEL, -9999, 1000, 0, 100, 1000);
      send_cmd(4, MODE_TRQ, 32767, 32767, 32767, 32767, 32767);
      send_cmd(4, MODE_POS, -32768, 32767, -32768, 32767, -32768);
   endtask

   initial begin
      reset                 = 1'b1;
      calm                  = 1'b0;
      quiet                 = 1'b0;
      sent                  = 0;
      cur_joint             = '0;
      cur_mode              = MODE_POS;
      req_bus.valid         = 1'b0;
      req_bus.joint_id      = '0;
      req_bus.ctrl_mode     = '0;
      req_bus.target_pos    = '0;
      req_bus.target_vel    = '0;
      req_bus.target_torque = '0;
      req_bus.meas_pos      = '0;
      req_bus.meas_vel      = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.addr          = '0;
      csr_bus.data          = '0;

      settings[0] = CfgReset;
      settings[1] = '{prop_gain: 16'd256, deriv_gain: 16'd256,
                      pos_lower: -16'sd4096, pos_upper: 16'sd4096,
                      vel_lower: -16'sd2048, vel_upper: 16'sd2048,
                      torque_lower: -16'sd1000, torque_upper: 16'sd1000};
      settings[2] = CfgReset;
      settings[2].prop_gain  = 16'd0;
      settings[2].deriv_gain = 16'd0;
      settings[3] = CfgReset;
      settings[3].prop_gain  = 16'hFFFF;
      settings[3].deriv_gain = 16'hFFFF;
      // Crossed limits: the upper bound is checked first; else the lower wins.
      settings[4] = '{prop_gain: 16'd1, deriv_gain: 16'hFFFF,
                      pos_lower: 16'sd1000, pos_upper: -16'sd1000,
                      vel_lower: 16'sd500, vel_upper: -16'sd500,
                      torque_lower: 16'sd200, torque_upper: -16'sd200};
      settings[5] = '{prop_gain: 16'($urandom), deriv_gain: 16'($urandom),
                      pos_lower: 16'(-int'($urandom_range(0, 32768))),
                      pos_upper: 16'($urandom_range(0, 32767)),
                      vel_lower: 16'(-int'($urandom_range(0, 32768))),
                      vel_upper: 16'($urandom_range(0, 32767)),
                      torque_lower: 16'(-int'($urandom_range(0, 32768))),
                      torque_upper: 16'($urandom_range(0, 32767))};
      settings[6] = '{prop_gain: 16'd17920, deriv_gain: 16'd794,
                      pos_lower: 16'sh7FFF, pos_upper: 16'sh8000,
                      vel_lower: 16'sh7FFF, vel_upper: 16'sh8000,
                      torque_lower: 16'sh7FFF, torque_upper: 16'sh8000};
      settings[7] = CfgReset;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_cmds();
      for (int p = 0; p < NumSettings; p++) begin
         if (p > 0) begin
            wait_idle();
            load_settings(settings[p], p == 4);
         end
         calm = (p == NumSettings - 1);
         repeat (PhaseItems) random_cmd();
      end
      wait_idle();
      repeat (10) @(posedge clock);

      $display("tb: %0d joint commands checked across %0d gain and limit settings,",
               sent, NumSettings);
      $display("tb: with random command gaps and result stalls in all but the last.");
      if (fails == 0 && pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
src/jpdmc_pkg.sv
src/jpdmc_if.sv
src/jpdmc_csr.sv
src/jpdmc_state_ram.sv
src/jpdmc_torque_pipe.sv
src/joint_pd_mode_controller_core.sv
bench/jpdmc_checker.sv
bench/tb.sv
